// ===== design/rpn_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types, codes and sizes of the reverse Polish stack evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(DATA_W);

    // token kinds
    localparam logic [2:0] KIND_PUSH = 3'd0;
    localparam logic [2:0] KIND_ADD  = 3'd1;
    localparam logic [2:0] KIND_SUB  = 3'd2;
    localparam logic [2:0] KIND_MUL  = 3'd3;
    localparam logic [2:0] KIND_DIV  = 3'd4;

    // result status
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO_DIV  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    typedef struct packed {
        logic [2:0]        kind;
        logic signed [31:0] operand;
        logic              last_token;
    } in_t;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic [4:0]        stack_depth;
        logic [1:0]        status;
        logic              expression_done;
    } out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_MUL_WB,
        S_DIV_WAIT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        CM_KEEP,
        CM_PUSH,
        CM_POP
    } commit_op_t;

    typedef enum logic [1:0] {
        RS_ADD,
        RS_SUB,
        RS_MUL,
        RS_DIV
    } res_sel_t;

    typedef struct packed {
        logic       load_token;
        logic       commit;
        commit_op_t op;
        res_sel_t   res_sel;
        logic [1:0] status;
        logic       mul_load;
        logic       div_start;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       full;
        logic       lt2;
        logic       top_zero;
        logic       div_done;
    } stat_t;

endpackage
`default_nettype wire

// ===== design/rpn_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_div
// Iterative signed divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module rpn_div
    import rpn_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [DATA_W-1:0] divisor,
    output logic                   done,
    output logic [DATA_W-1:0]      quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] den_reg;

    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] rem_next;
    logic [DATA_W-1:0] quo_next;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DATA_W-1]};
        diff  = trial - {1'b0, den_reg};
        if (!diff[DATA_W])
        begin
            rem_next = diff[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DATA_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operands as magnitudes, sign applied at the end
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
            quo_reg <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            den_reg <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule
`default_nettype wire

// ===== design/rpn_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_ctrl
// Token sequencer: decodes a token, checks errors, steps the datapath.
// ----------------------------------------------------------------------------
module rpn_ctrl
    import rpn_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire stat_t stat,
    output logic       busy,
    output cmd_t       cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                if ((stat.kind inside {KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV}) && !stat.lt2
                    && !((stat.kind == KIND_DIV) && stat.top_zero))
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (stat.kind)
                    KIND_MUL: state_next = S_MUL_WB;
                    KIND_DIV: state_next = S_DIV_WAIT;
                    default:  state_next = S_IDLE;
                endcase
            end
            S_MUL_WB:
            begin
                state_next = S_IDLE;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.op         = CM_KEEP;
        cmd.res_sel    = RS_ADD;
        cmd.status     = ST_OK;
        busy           = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_token = start;
            end
            S_DECODE:
            begin
                case (stat.kind)
                    KIND_PUSH:
                    begin
                        cmd.commit = 1'b1;
                        if (stat.full)
                        begin
                            cmd.status = ST_OVERFLOW;
                        end
                        else
                        begin
                            cmd.op = CM_PUSH;
                        end
                    end
                    KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV:
                    begin
                        if (stat.lt2)
                        begin
                            cmd.commit = 1'b1;
                            cmd.status = ST_UNDERFLOW;
                        end
                        else if ((stat.kind == KIND_DIV) && stat.top_zero)
                        begin
                            cmd.commit = 1'b1;
                            cmd.status = ST_ZERO_DIV;
                        end
                    end
                    default:
                    begin
                        // unknown kind: report, no stack change
                        cmd.commit = 1'b1;
                    end
                endcase
            end
            S_EXEC:
            begin
                case (stat.kind)
                    KIND_ADD:
                    begin
                        cmd.commit  = 1'b1;
                        cmd.op      = CM_POP;
                        cmd.res_sel = RS_ADD;
                    end
                    KIND_SUB:
                    begin
                        cmd.commit  = 1'b1;
                        cmd.op      = CM_POP;
                        cmd.res_sel = RS_SUB;
                    end
                    KIND_MUL: cmd.mul_load  = 1'b1;
                    KIND_DIV: cmd.div_start = 1'b1;
                    default:  cmd.commit    = 1'b1;
                endcase
            end
            S_MUL_WB:
            begin
                cmd.commit  = 1'b1;
                cmd.op      = CM_POP;
                cmd.res_sel = RS_MUL;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.commit  = 1'b1;
                    cmd.op      = CM_POP;
                    cmd.res_sel = RS_DIV;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/rpn_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_dpath
// Stack storage, cached top entry, ALU, divider and result register.
// ----------------------------------------------------------------------------
module rpn_dpath
    import rpn_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire in_t  token,
    input  wire cmd_t cmd,
    output stat_t     stat,
    output out_t      result,
    output logic      result_valid
);

    // entries below the top live in the memory; the top is cached
    logic [DATA_W-1:0]  mem [STACK_DEPTH];
    logic [DATA_W-1:0]  nos_reg;
    logic [DATA_W-1:0]  top_reg;
    logic [DATA_W-1:0]  top_next;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic [DEPTH_W-1:0] depth_store;
    logic [DATA_W-1:0]  mul_reg;
    in_t                tok_reg;
    out_t               result_reg;
    out_t               result_next;
    logic               valid_reg;

    logic [DEPTH_W-1:0] depth_m1;
    logic [DEPTH_W-1:0] depth_m2;
    logic               mem_we;
    logic [DATA_W-1:0]  alu_res;
    logic               div_done;
    logic [DATA_W-1:0]  div_q;

    assign depth_m1 = depth_reg - 1'b1;
    assign depth_m2 = depth_reg - DEPTH_W'(2);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[depth_m1[ADDR_W-1:0]] <= top_reg;
        end
        nos_reg <= mem[depth_m2[ADDR_W-1:0]];
    end

    rpn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (nos_reg),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        case (cmd.res_sel)
            RS_ADD:  alu_res = nos_reg + top_reg;
            RS_SUB:  alu_res = nos_reg - top_reg;
            RS_MUL:  alu_res = mul_reg;
            RS_DIV:  alu_res = div_q;
            default: alu_res = '0;
        endcase
    end

    always_comb
    begin
        top_next   = top_reg;
        depth_next = depth_reg;
        mem_we     = 1'b0;
        if (cmd.commit)
        begin
            case (cmd.op)
                CM_PUSH:
                begin
                    mem_we     = (depth_reg != '0);
                    top_next   = tok_reg.operand;
                    depth_next = depth_reg + 1'b1;
                end
                CM_POP:
                begin
                    top_next   = alu_res;
                    depth_next = depth_m1;
                end
                default:
                begin
                    top_next = top_reg;
                end
            endcase
        end
        depth_store = (cmd.commit && tok_reg.last_token) ? '0 : depth_next;

        result_next.top_value       = (depth_next != '0) ? top_next : '0;
        result_next.stack_depth     = 5'(depth_next);
        result_next.status          = cmd.status;
        result_next.expression_done = tok_reg.last_token;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg <= depth_store;
            valid_reg <= cmd.commit;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (cmd.load_token)
        begin
            tok_reg <= token;
        end
        if (cmd.mul_load)
        begin
            mul_reg <= nos_reg * top_reg;
        end
        if (cmd.commit)
        begin
            result_reg <= result_next;
        end
    end

    assign stat.kind     = tok_reg.kind;
    assign stat.full     = (depth_reg >= DEPTH_W'(STACK_DEPTH));
    assign stat.lt2      = (depth_reg < DEPTH_W'(2));
    assign stat.top_zero = (top_reg == '0);
    assign stat.div_done = div_done;

    assign result       = result_reg;
    assign result_valid = valid_reg;

endmodule
`default_nettype wire

// ===== design/rpn_stack_evaluator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// Reverse Polish evaluator: one token per beat, one result beat per token.
// ----------------------------------------------------------------------------
//
//  channel   ports                     handshake
//  -------   -----------------------   ------------------------------------
//  token     token (in_t)              taken on start high and busy low
//  result    result (out_t)            result_valid strobe, one cycle
//
//  Steps per token after acceptance; the result is registered at commit:
//    push, unknown kind, any error .... commit in decode
//    add, subtract .................... commit in exec
//    multiply ......................... product in exec, commit in S_MUL_WB
//    divide ........................... divider start in exec, commit in
//                                           S_DIV_WAIT once rpn_div is done
//  A new token is taken in the cycle its predecessor's result is shown.
//  Reset clears the depth and the sequencer; stack contents are not cleared.
//  The result side has no back-pressure: each beat shows exactly once.
//
//  Structure: rpn_ctrl sequences each token; rpn_dpath holds the stack
//  memory (single write, single registered read of the second entry), the
//  cached top entry, the ALU and the iterative divider rpn_div.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator
    import rpn_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire in_t  token,
    output out_t      result,
    output logic      result_valid
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer: decode, error checks, multi-cycle op steps
    rpn_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // storage and arithmetic
    rpn_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .token        (token),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule
`default_nettype wire

// ===== tb/tb_rpn_stack_evaluator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_rpn_stack_evaluator
// Self-checking bench for the reverse Polish stack evaluator. A token driver
// feeds beats from a queue. A monitor predicts every accepted token on its
// own copy of the stack and checks each result beat against the oldest
// prediction. The run starts with directed corner tokens, then random
// expressions, most of them well formed.
// ----------------------------------------------------------------------------
module tb_rpn_stack_evaluator;

    import rpn_pkg::*;

    localparam int N_RANDOM    = 950;
    localparam int IDLE_PCT    = 26;
    localparam int DRAIN_CYC   = 40;
    localparam int TIMEOUT     = 2_000_000;  // far above a clean run

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    in_t  token = '0;
    logic busy;
    out_t result;
    logic result_valid;

    rpn_stack_evaluator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .token        (token),
        .result       (result),
        .result_valid (result_valid)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // tokens waiting to be driven, and results predicted but not yet seen
    in_t  token_queue[$];
    out_t expected_results[$];

    // handshake bookkeeping: each counter has exactly one writer
    int unsigned n_presented = 0;   // driver: beats put on the port
    int unsigned n_accepted  = 0;   // monitor: beats taken by the block
    int unsigned n_errors    = 0;

    // predictor's own copy of the evaluator state
    logic [31:0] calc_stack [STACK_DEPTH];
    int          calc_depth = 0;

    // Applies one token to the predicted stack and returns the result beat.
    // Errors leave the stack alone; a last token clears it after reporting.
    function automatic out_t eval_token(in_t t);
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic [31:0] res;
        logic [31:0] mag_l;
        logic [31:0] mag_r;
        logic [31:0] quo;
        logic [1:0]  st;
        logic        ok;
        out_t        r;
        st  = ST_OK;
        ok  = 1'b1;
        res = '0;
        if (t.kind == KIND_PUSH)
        begin
            if (calc_depth >= STACK_DEPTH)
                st = ST_OVERFLOW;
            else
            begin
                calc_stack[calc_depth] = t.operand;
                calc_depth++;
            end
        end
        else if (t.kind <= KIND_DIV)
        begin
            if (calc_depth < 2)
                st = ST_UNDERFLOW;
            else
            begin
                rhs = calc_stack[calc_depth - 1];
                lhs = calc_stack[calc_depth - 2];
                case (t.kind)
                    KIND_ADD: res = lhs + rhs;
                    KIND_SUB: res = lhs - rhs;
                    KIND_MUL: res = lhs * rhs;   // low 32 bits, sign-agnostic
                    default:
                    begin
                        if (rhs == '0)
                        begin
                            ok = 1'b0;
                            st = ST_ZERO_DIV;
                        end
                        else
                        begin
                            // truncate toward zero on magnitudes; min / -1 wraps
                            mag_l = lhs[31] ? -lhs : lhs;
                            mag_r = rhs[31] ? -rhs : rhs;
                            quo   = mag_l / mag_r;
                            res   = (lhs[31] ^ rhs[31]) ? -quo : quo;
                        end
                    end
                endcase
                if (ok)
                begin
                    calc_depth--;
                    calc_stack[calc_depth - 1] = res;
                end
            end
        end
        // unknown kinds fall through: status ok, stack untouched
        r.top_value       = (calc_depth > 0) ? calc_stack[calc_depth - 1] : '0;
        r.stack_depth     = 5'(calc_depth);
        r.status          = st;
        r.expression_done = t.last_token;
        if (t.last_token)
            calc_depth = 0;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Token driver. Changes on the falling edge. A beat stays on the port
    // until the monitor has seen it taken; then the next one goes out, or
    // start drops for an idle cycle. Idling is rolled every cycle, so gaps
    // land both while the block is busy and right at the point it frees up.
    // Tokens 300..449 go out back to back with no idling.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || n_accepted == n_presented)
        begin
            if (token_queue.size() != 0 &&
                ((n_presented >= 300 && n_presented < 450) ||
                 $urandom_range(99) >= IDLE_PCT))
            begin
                token       <= token_queue.pop_front();
                start       <= 1'b1;
                n_presented <= n_presented + 1;
            end
            else
                start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Samples on the rising edge. A result beat is checked against
    // the oldest prediction before the token accepted on the same edge (the
    // block takes the next token while showing the previous result) is
    // predicted and queued.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no token outstanding");
                    n_errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.top_value !== want.top_value)
                    begin
                        $error("top_value: expected %0d, got %0d",
                               want.top_value, result.top_value);
                        n_errors++;
                    end
                    if (result.stack_depth !== want.stack_depth)
                    begin
                        $error("stack_depth: expected %0d, got %0d",
                               want.stack_depth, result.stack_depth);
                        n_errors++;
                    end
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               want.status, result.status);
                        n_errors++;
                    end
                    if (result.expression_done !== want.expression_done)
                    begin
                        $error("expression_done: expected %0b, got %0b",
                               want.expression_done, result.expression_done);
                        n_errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                expected_results.push_back(eval_token(token));
                n_accepted <= n_accepted + 1;
            end
        end
    end

    task automatic queue_token(logic [2:0] kind, logic [31:0] operand, logic last);
        in_t t;
        t.kind       = kind;
        t.operand    = operand;
        t.last_token = last;
        token_queue.push_back(t);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int          n_random;
        int          gen_depth;
        int          expr_len;
        int          roll;
        bit          deep;
        bit          last;
        logic [2:0]  kind;
        logic [31:0] operand;

        // directed: underflow on an empty and a one-entry stack,
        // most negative / -1 wrap, zero divisor, ignored unknown kind on
        // the last token, add/mul/sub wrapping at the extremes
        queue_token(KIND_ADD,  32'h0,         1'b0);
        queue_token(KIND_PUSH, 32'h8000_0000, 1'b0);
        queue_token(KIND_SUB,  32'h0,         1'b0);
        queue_token(KIND_PUSH, 32'hFFFF_FFFF, 1'b0);
        queue_token(KIND_DIV,  32'h0,         1'b0);
        queue_token(KIND_PUSH, 32'h0,         1'b0);
        queue_token(KIND_DIV,  32'h0,         1'b0);
        queue_token(3'd7,      32'hFFFF_FFFF, 1'b1);
        queue_token(KIND_PUSH, 32'h7FFF_FFFF, 1'b0);
        queue_token(KIND_PUSH, 32'h7FFF_FFFF, 1'b0);
        queue_token(KIND_ADD,  32'h0,         1'b0);
        queue_token(KIND_PUSH, 32'h7FFF_FFFF, 1'b0);
        queue_token(KIND_MUL,  32'h0,         1'b0);
        queue_token(KIND_PUSH, 32'h8000_0000, 1'b0);
        queue_token(KIND_SUB,  32'h0,         1'b0);
        // fill to the top, then push once more on a full stack as the
        // last token: overflow is reported and the stack still clears
        for (int i = 1; i < STACK_DEPTH; i++)
            queue_token(KIND_PUSH, (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF, 1'b0);
        queue_token(KIND_PUSH, 32'h1234_5678, 1'b1);

        // random expressions: mostly well formed, with some stray tokens
        // (unknown kinds, operators on a short stack, early last tokens);
        // about one in ten drives the stack to full and beyond
        n_random = 0;
        while (n_random < N_RANDOM)
        begin
            gen_depth = 0;
            deep      = ($urandom_range(9) == 0);
            expr_len  = deep ? $urandom_range(17, 26) : $urandom_range(1, 40);
            for (int i = 0; i < expr_len; i++)
            begin
                roll = $urandom_range(99);
                last = (i == expr_len - 1) || ($urandom_range(99) == 0);
                if (roll < 6)
                    kind = 3'($urandom_range(7));
                else if ((deep && i < 17) || gen_depth < 2 ||
                         (roll < 50 && gen_depth < STACK_DEPTH))
                    kind = KIND_PUSH;
                else
                    kind = 3'(KIND_ADD + $urandom_range(3));

                if (kind == KIND_PUSH)
                begin
                    case ($urandom_range(9))
                        0:       operand = 32'h8000_0000;
                        1:       operand = 32'h7FFF_FFFF;
                        2:       operand = 32'hFFFF_FFFF;
                        3, 4, 5: operand = $urandom_range(16) - 8;  // hits zero
                        default: operand = $urandom();
                    endcase
                    if (gen_depth < STACK_DEPTH)
                        gen_depth++;
                end
                else
                begin
                    operand = $urandom();   // ignored by the block
                    if (kind <= KIND_DIV && gen_depth >= 2)
                        gen_depth--;
                end
                queue_token(kind, operand, last);
                n_random++;
                if (last)
                    break;
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (token_queue.size() == 0 && n_accepted == n_presented);
        wait (expected_results.size() == 0);
        // any stray beat in this window is flagged by the monitor
        repeat (DRAIN_CYC) @(posedge clk);

        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #TIMEOUT;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
